// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the level resource top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that pre implies post in the same cycle, outside reset.
`define BLRW_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check that pre implies post in the next cycle, outside reset.
`define BLRW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/blrw_pkg.sv =====
// ----------------------------------------------------------------------------
// blrw_pkg
// Shared types and fixed widths of the bounded level resource with waiters.
// ----------------------------------------------------------------------------
package blrw_pkg;

  // Fixed field widths
  localparam int REQ_W       = 8;
  localparam int CAP_W       = 16;
  localparam int LEVEL_OUT_W = 16;
  localparam int OUTC_W      = 2;

  // Results one request may cause at most
  localparam int MAX_RESULTS = 17;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd15;

  // Request queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QFILL_W = 2;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_PUT    = 2'd0,
    OUTC_GET    = 2'd1,
    OUTC_REJECT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_START,
    ST_SCAN_EVAL,
    ST_FLUSH
  } state_t;

  // Classified request header
  typedef struct packed {
    op_t              op;
    logic [REQ_W-1:0] requester;
  } req_hdr_t;

  // Back-end status for the top level
  typedef struct packed {
    logic idle;
    logic pend_valid;
  } back_stat_t;

endpackage

// ===== design/blrw_front.sv =====
// ----------------------------------------------------------------------------
// blrw_front
// Accepts requests, classifies them as put or get and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module blrw_front #(
  parameter int AMOUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [blrw_pkg::REQ_W-1:0]     in_requester,
  input  logic [AMOUNT_BITS-1:0]         in_amount,
  output logic                           q_valid,
  output blrw_pkg::req_hdr_t             q_hdr,
  output logic [AMOUNT_BITS-1:0]         q_amount,
  input  logic                           q_pop
);

  blrw_pkg::req_hdr_t                hdr_mem_r [blrw_pkg::QDEPTH];
  logic [AMOUNT_BITS-1:0]            amt_mem_r [blrw_pkg::QDEPTH];
  logic [blrw_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [blrw_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [blrw_pkg::QFILL_W-1:0]      fill_r, fill_nxt;
  logic                              push;
  logic                              pop;
  blrw_pkg::req_hdr_t                in_hdr;

  // Classify the incoming transaction
  always_comb begin
    in_hdr.op        = in_operation ? blrw_pkg::OP_GET : blrw_pkg::OP_PUT;
    in_hdr.requester = in_requester;
  end

  assign in_stall = (fill_r == blrw_pkg::QFILL_W'(blrw_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_hdr    = hdr_mem_r[rd_ptr_r];
  assign q_amount = amt_mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + blrw_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + blrw_pkg::QPTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + blrw_pkg::QFILL_W'(1);
      2'b01:   fill_nxt = fill_r - blrw_pkg::QFILL_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      hdr_mem_r[wr_ptr_r] <= in_hdr;
      amt_mem_r[wr_ptr_r] <= in_amount;
    end
  end

endmodule

// ===== design/blrw_list.sv =====
// ----------------------------------------------------------------------------
// blrw_list
// Waiter list storage: one write port and one registered read port holding
// requester and amount of each waiting entry.
// ----------------------------------------------------------------------------
module blrw_list #(
  parameter int  WAITER_DEPTH = 8,
  parameter int  AMOUNT_BITS  = 16,
  localparam int IDX_W        = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [blrw_pkg::REQ_W-1:0] wr_id,
  input  logic [AMOUNT_BITS-1:0]     wr_amount,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [blrw_pkg::REQ_W-1:0] rd_id,
  output logic [AMOUNT_BITS-1:0]     rd_amount
);

  logic [blrw_pkg::REQ_W-1:0] id_mem  [WAITER_DEPTH];
  logic [AMOUNT_BITS-1:0]     amt_mem [WAITER_DEPTH];
  logic [blrw_pkg::REQ_W-1:0] rd_id_r;
  logic [AMOUNT_BITS-1:0]     rd_amount_r;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      amt_mem[wr_addr] <= wr_amount;
    end
    rd_id_r     <= id_mem[rd_addr];
    rd_amount_r <= amt_mem[rd_addr];
  end

  assign rd_id     = rd_id_r;
  assign rd_amount = rd_amount_r;

endmodule

// ===== design/blrw_back.sv =====
// ----------------------------------------------------------------------------
// blrw_back
// Appends queued requests to their waiter list, rejects those whose list is
// full, and runs alternating put and get scans that grant waiters in order.
// ----------------------------------------------------------------------------
module blrw_back #(
  parameter int WAITER_DEPTH = 8,
  parameter int AMOUNT_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [blrw_pkg::CAP_W-1:0]       cfg_wr_data,
  input  logic                             q_valid,
  input  blrw_pkg::req_hdr_t               q_hdr,
  input  logic [AMOUNT_BITS-1:0]           q_amount,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [blrw_pkg::REQ_W-1:0]       out_granted_to,
  output logic [blrw_pkg::OUTC_W-1:0]      out_outcome,
  output logic [blrw_pkg::LEVEL_OUT_W-1:0] out_level_after,
  output logic                             out_last,
  output blrw_pkg::back_stat_t             stat
);

  localparam int IDX_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAITER_DEPTH + 1);
  localparam int CW    = (AMOUNT_BITS > blrw_pkg::CAP_W) ? AMOUNT_BITS : blrw_pkg::CAP_W;
  localparam int RC_W  = blrw_pkg::RES_CNT_W;
  localparam int LO_W  = blrw_pkg::LEVEL_OUT_W;

  // Control state
  blrw_pkg::state_t             state_r, state_nxt;
  logic [blrw_pkg::CAP_W-1:0]   capacity_r;
  logic [AMOUNT_BITS-1:0]       level_r, level_nxt;
  logic [CNT_W-1:0]             put_cnt_r, put_cnt_nxt;
  logic [CNT_W-1:0]             get_cnt_r, get_cnt_nxt;
  blrw_pkg::op_t                sel_r, sel_nxt;
  logic [CNT_W-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [RC_W-1:0]              res_n_r, res_n_nxt;
  logic                         round_grant_r, round_grant_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Result payload
  logic [blrw_pkg::REQ_W-1:0]   pend_id_r, pend_id_nxt;
  blrw_pkg::outcome_t           pend_outc_r, pend_outc_nxt;
  logic [LO_W-1:0]              pend_level_r, pend_level_nxt;
  logic [blrw_pkg::REQ_W-1:0]   out_id_r, out_id_nxt;
  blrw_pkg::outcome_t           out_outc_r, out_outc_nxt;
  logic [LO_W-1:0]              out_level_r, out_level_nxt;
  logic                         out_last_r, out_last_nxt;

  // Datapath
  logic                         out_free;
  logic [CNT_W-1:0]             hdr_cnt;
  logic                         hdr_full;
  logic [CNT_W-1:0]             sel_cnt;
  logic                         in_range;
  logic [CNT_W-1:0]             rd_ptr_inc;
  logic [blrw_pkg::REQ_W-1:0]   p_rd_id, g_rd_id, rd_id;
  logic [AMOUNT_BITS-1:0]       p_rd_amt, g_rd_amt, rd_amt;
  logic [CW-1:0]                cap_ext, amt_max_ext, level_ext, grant_level_ext;
  logic [AMOUNT_BITS-1:0]       eff_cap;
  logic [AMOUNT_BITS:0]         put_sum;
  logic                         fits;
  logic                         res_below;
  logic                         grant;
  logic                         advance;
  logic [AMOUNT_BITS-1:0]       grant_level;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             wr_addr;
  logic [blrw_pkg::REQ_W-1:0]   wr_id;
  logic [AMOUNT_BITS-1:0]       wr_amt;
  logic                         p_wr_en, g_wr_en;

  blrw_list #(
    .WAITER_DEPTH (WAITER_DEPTH),
    .AMOUNT_BITS  (AMOUNT_BITS)
  ) u_put_list (
    .clk       (clk),
    .wr_en     (p_wr_en),
    .wr_addr   (wr_addr),
    .wr_id     (wr_id),
    .wr_amount (wr_amt),
    .rd_addr   (rd_addr),
    .rd_id     (p_rd_id),
    .rd_amount (p_rd_amt)
  );

  blrw_list #(
    .WAITER_DEPTH (WAITER_DEPTH),
    .AMOUNT_BITS  (AMOUNT_BITS)
  ) u_get_list (
    .clk       (clk),
    .wr_en     (g_wr_en),
    .wr_addr   (wr_addr),
    .wr_id     (wr_id),
    .wr_amount (wr_amt),
    .rd_addr   (rd_addr),
    .rd_id     (g_rd_id),
    .rd_amount (g_rd_amt)
  );

  // Classify the queue head and the list under scan
  assign out_free   = !out_valid_r || !out_stall;
  assign hdr_cnt    = (q_hdr.op == blrw_pkg::OP_GET) ? get_cnt_r : put_cnt_r;
  assign hdr_full   = (hdr_cnt == CNT_W'(WAITER_DEPTH));
  assign sel_cnt    = (sel_r == blrw_pkg::OP_GET) ? get_cnt_r : put_cnt_r;
  assign in_range   = (rd_ptr_r < sel_cnt);
  assign rd_ptr_inc = rd_ptr_r + CNT_W'(1);
  assign rd_id      = (sel_r == blrw_pkg::OP_GET) ? g_rd_id : p_rd_id;
  assign rd_amt     = (sel_r == blrw_pkg::OP_GET) ? g_rd_amt : p_rd_amt;

  // Limit capacity to what the level can hold
  assign cap_ext     = CW'(capacity_r);
  assign amt_max_ext = CW'({AMOUNT_BITS{1'b1}});
  assign eff_cap     = (cap_ext > amt_max_ext) ? amt_max_ext[AMOUNT_BITS-1:0]
                                               : cap_ext[AMOUNT_BITS-1:0];

  // Grant test for the entry under scan
  assign put_sum   = {1'b0, level_r} + {1'b0, rd_amt};
  assign res_below = (res_n_r < RC_W'(blrw_pkg::MAX_RESULTS));
  always_comb begin
    if (sel_r == blrw_pkg::OP_GET) begin
      fits        = (level_r >= rd_amt);
      grant_level = level_r - rd_amt;
    end else begin
      fits        = (put_sum <= {1'b0, eff_cap});
      grant_level = put_sum[AMOUNT_BITS-1:0];
    end
  end
  assign grant   = fits && res_below;
  assign advance = !grant || !pend_valid_r || out_free;

  assign level_ext       = CW'(level_r);
  assign grant_level_ext = CW'(grant_level);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blrw_pkg::ST_IDLE: begin
        if (q_valid && !hdr_full) state_nxt = blrw_pkg::ST_SCAN_START;
      end
      blrw_pkg::ST_SCAN_START: state_nxt = blrw_pkg::ST_SCAN_EVAL;
      blrw_pkg::ST_SCAN_EVAL: begin
        if (!in_range) begin
          if (sel_r == blrw_pkg::OP_PUT || (round_grant_r && res_below)) begin
            state_nxt = blrw_pkg::ST_SCAN_START;
          end else begin
            state_nxt = blrw_pkg::ST_FLUSH;
          end
        end
      end
      blrw_pkg::ST_FLUSH: begin
        if (!pend_valid_r || out_free) state_nxt = blrw_pkg::ST_IDLE;
      end
      default: state_nxt = blrw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    level_nxt       = level_r;
    put_cnt_nxt     = put_cnt_r;
    get_cnt_nxt     = get_cnt_r;
    sel_nxt         = sel_r;
    rd_ptr_nxt      = rd_ptr_r;
    wr_ptr_nxt      = wr_ptr_r;
    res_n_nxt       = res_n_r;
    round_grant_nxt = round_grant_r;
    pend_valid_nxt  = pend_valid_r;
    pend_id_nxt     = pend_id_r;
    pend_outc_nxt   = pend_outc_r;
    pend_level_nxt  = pend_level_r;
    out_valid_nxt   = out_valid_r;
    out_id_nxt      = out_id_r;
    out_outc_nxt    = out_outc_r;
    out_level_nxt   = out_level_r;
    out_last_nxt    = out_last_r;
    q_pop           = 1'b0;
    p_wr_en         = 1'b0;
    g_wr_en         = 1'b0;
    wr_addr         = '0;
    wr_id           = q_hdr.requester;
    wr_amt          = q_amount;
    rd_addr         = '0;

    // Drop a result once it is taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      blrw_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (hdr_full) begin
            // Reject straight to the output register
            if (out_free) begin
              q_pop         = 1'b1;
              out_valid_nxt = 1'b1;
              out_id_nxt    = q_hdr.requester;
              out_outc_nxt  = blrw_pkg::OUTC_REJECT;
              out_level_nxt = level_ext[LO_W-1:0];
              out_last_nxt  = 1'b1;
            end
          end else begin
            // Append to the tail of the matching list
            q_pop   = 1'b1;
            wr_addr = hdr_cnt[IDX_W-1:0];
            if (q_hdr.op == blrw_pkg::OP_GET) begin
              g_wr_en     = 1'b1;
              get_cnt_nxt = get_cnt_r + CNT_W'(1);
            end else begin
              p_wr_en     = 1'b1;
              put_cnt_nxt = put_cnt_r + CNT_W'(1);
            end
            sel_nxt         = blrw_pkg::OP_PUT;
            res_n_nxt       = '0;
            round_grant_nxt = 1'b0;
          end
        end
      end

      blrw_pkg::ST_SCAN_START: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
        rd_addr    = '0;
      end

      blrw_pkg::ST_SCAN_EVAL: begin
        if (in_range) begin
          rd_addr = advance ? rd_ptr_inc[IDX_W-1:0] : rd_ptr_r[IDX_W-1:0];
          if (advance) begin
            rd_ptr_nxt = rd_ptr_inc;
            if (grant) begin
              // Release the previous grant, hold this one until the next
              level_nxt       = grant_level;
              res_n_nxt       = res_n_r + RC_W'(1);
              round_grant_nxt = 1'b1;
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_id_nxt    = pend_id_r;
                out_outc_nxt  = pend_outc_r;
                out_level_nxt = pend_level_r;
                out_last_nxt  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_id_nxt    = rd_id;
              pend_outc_nxt  = (sel_r == blrw_pkg::OP_GET) ? blrw_pkg::OUTC_GET
                                                           : blrw_pkg::OUTC_PUT;
              pend_level_nxt = grant_level_ext[LO_W-1:0];
            end else begin
              // Keep the entry, compacting toward the head
              wr_addr    = wr_ptr_r[IDX_W-1:0];
              wr_id      = rd_id;
              wr_amt     = rd_amt;
              wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
              if (sel_r == blrw_pkg::OP_GET) begin
                g_wr_en = 1'b1;
              end else begin
                p_wr_en = 1'b1;
              end
            end
          end
        end else begin
          // End of list: shrink it to the kept entries
          if (sel_r == blrw_pkg::OP_GET) begin
            get_cnt_nxt = wr_ptr_r;
          end else begin
            put_cnt_nxt = wr_ptr_r;
          end
          if (sel_r == blrw_pkg::OP_PUT) begin
            sel_nxt = blrw_pkg::OP_GET;
          end else if (round_grant_r && res_below) begin
            sel_nxt         = blrw_pkg::OP_PUT;
            round_grant_nxt = 1'b0;
          end
        end
      end

      blrw_pkg::ST_FLUSH: begin
        // Send the held grant as the final result
        if (pend_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = pend_id_r;
          out_outc_nxt   = pend_outc_r;
          out_level_nxt  = pend_level_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= blrw_pkg::ST_IDLE;
      capacity_r    <= blrw_pkg::CAP_RESET;
      level_r       <= '0;
      put_cnt_r     <= '0;
      get_cnt_r     <= '0;
      sel_r         <= blrw_pkg::OP_PUT;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      res_n_r       <= '0;
      round_grant_r <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
      level_r       <= level_nxt;
      put_cnt_r     <= put_cnt_nxt;
      get_cnt_r     <= get_cnt_nxt;
      sel_r         <= sel_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      res_n_r       <= res_n_nxt;
      round_grant_r <= round_grant_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_id_r    <= pend_id_nxt;
    pend_outc_r  <= pend_outc_nxt;
    pend_level_r <= pend_level_nxt;
    out_id_r     <= out_id_nxt;
    out_outc_r   <= out_outc_nxt;
    out_level_r  <= out_level_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_granted_to  = out_id_r;
  assign out_outcome     = out_outc_r;
  assign out_level_after = out_level_r;
  assign out_last        = out_last_r;

  assign stat.idle       = (state_r == blrw_pkg::ST_IDLE);
  assign stat.pend_valid = pend_valid_r;

endmodule

// ===== design/bounded_level_resource_with_waiters.sv =====
// Results: a reject passes from the front queue straight into the output register
//   once the back end is idle and the output is free; a grant is held in a pending
//   register and moves to the output register once the next grant or the end of
//   the scans is found. Scans run R rounds over P put and G get waiters, one entry
//   per cycle through each list's single read port while the output is not stalled.
// Reset (synchronous, rst_n low): level 0, both lists empty, capacity 15.
// ----------------------------------------------------------------------------
// bounded_level_resource_with_waiters
// Level resource with a capacity register and ordered put and get waiter lists;
// grants every waiter that fits after each request, up to 17 results per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_level_resource_with_waiters #(
  parameter int WAITER_DEPTH = 8,
  parameter int AMOUNT_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [blrw_pkg::CAP_W-1:0]       cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [blrw_pkg::REQ_W-1:0]       in_requester,
  input  logic [AMOUNT_BITS-1:0]           in_amount,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [blrw_pkg::REQ_W-1:0]       out_granted_to,
  output logic [blrw_pkg::OUTC_W-1:0]      out_outcome,
  output logic [blrw_pkg::LEVEL_OUT_W-1:0] out_level_after,
  output logic                             out_last
);

  logic                       q_valid;
  blrw_pkg::req_hdr_t         q_hdr;
  logic [AMOUNT_BITS-1:0]     q_amount;
  logic                       q_pop;
  blrw_pkg::back_stat_t       stat;
  logic                       rej_seen;
  logic                       mid_taken;
  logic                       more_due;

  blrw_front #(
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_requester (in_requester),
    .in_amount    (in_amount),
    .q_valid      (q_valid),
    .q_hdr        (q_hdr),
    .q_amount     (q_amount),
    .q_pop        (q_pop)
  );

  blrw_back #(
    .WAITER_DEPTH (WAITER_DEPTH),
    .AMOUNT_BITS  (AMOUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .q_valid         (q_valid),
    .q_hdr           (q_hdr),
    .q_amount        (q_amount),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted_to  (out_granted_to),
    .out_outcome     (out_outcome),
    .out_level_after (out_level_after),
    .out_last        (out_last),
    .stat            (stat)
  );

  // Qualifiers for the checks below
  assign rej_seen  = out_valid && (out_outcome == blrw_pkg::OUTC_REJECT);
  assign mid_taken = out_valid && !out_stall && !out_last;
  assign more_due  = out_valid || stat.pend_valid;

  // A reject is always the only result of its request
  `BLRW_ASSERT_IMP(a_reject_is_last, rej_seen, out_last, "reject result without last")

  // No grant may be left held once the sequencer is idle
  `BLRW_ASSERT_IMP(a_idle_no_pending, stat.idle, !stat.pend_valid, "grant held while idle")

  // A non-final result is always followed by one already waiting
  `BLRW_ASSERT_NEXT(a_more_after_non_last, mid_taken, more_due, "nothing after non-final")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded level resource with waiters. Requests
// are settled against a local copy of the level and both waiter lists, and
// every grant or reject leaving the block is checked in order, field by field.
// Capacity is reprogrammed between phases, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH         = 8;
  localparam int AMT_W         = 16;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int STUCK_LIMIT   = 5000;
  localparam int RAND_PHASES   = 7;
  localparam int PHASE_ITEMS   = 36;
  localparam int HOLD_PHASE    = 2;
  localparam int CALM_PHASE    = 4;

  typedef struct {
    blrw_pkg::op_t              op;
    logic [blrw_pkg::REQ_W-1:0] who;
    logic [AMT_W-1:0]           amt;
  } req_t;

  typedef struct {
    logic [blrw_pkg::REQ_W-1:0]       who;
    blrw_pkg::outcome_t               outc;
    logic [blrw_pkg::LEVEL_OUT_W-1:0] lvl;
    logic                             last;
  } grant_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [blrw_pkg::CAP_W-1:0]       cfg_wr_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_operation = 1'b0;
  logic [blrw_pkg::REQ_W-1:0]       in_requester = '0;
  logic [AMT_W-1:0]                 in_amount = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [blrw_pkg::REQ_W-1:0]       out_granted_to;
  logic [blrw_pkg::OUTC_W-1:0]      out_outcome;
  logic [blrw_pkg::LEVEL_OUT_W-1:0] out_level_after;
  logic                             out_last;

  req_t   pend_q[$];
  grant_t grant_q[$];
  int     err_cnt = 0;
  int     phase_no = 0;

  // Local copy of the resource: index 0 is the put list, index 1 the get list
  int unsigned                lvl_m;
  int unsigned                cap_m;
  logic [blrw_pkg::REQ_W-1:0] wid[2][DEPTH];
  int unsigned                wamt[2][DEPTH];
  int                         wn[2];
  int                         step_n;
  grant_t                     held_grant;
  bit                         held_valid;

  bounded_level_resource_with_waiters #(
    .WAITER_DEPTH(DEPTH),
    .AMOUNT_BITS (AMT_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_requester   (in_requester),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_granted_to (out_granted_to),
    .out_outcome    (out_outcome),
    .out_level_after(out_level_after),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold back each grant until the next one shows whether it ends the request
  function automatic void post_grant(logic [blrw_pkg::REQ_W-1:0] who,
                                     blrw_pkg::outcome_t outc);
    if (held_valid) grant_q.insert(grant_q.size(), held_grant);
    held_grant = '{who, outc, lvl_m[blrw_pkg::LEVEL_OUT_W-1:0], 1'b0};
    held_valid = 1'b1;
    step_n++;
  endfunction

  // One ordered pass over a waiter list; returns the number of grants
  function automatic int scan_waiters(int k);
    int i = 0;
    int granted = 0;
    bit fits;
    while (i < wn[k]) begin
      if (step_n >= blrw_pkg::MAX_RESULTS) break;
      fits = (k == 1) ? (lvl_m >= wamt[k][i]) : (lvl_m + wamt[k][i] <= cap_m);
      if (fits) begin
        if (k == 1) lvl_m -= wamt[k][i];
        else lvl_m += wamt[k][i];
        post_grant(wid[k][i], (k == 1) ? blrw_pkg::OUTC_GET : blrw_pkg::OUTC_PUT);
        for (int j = i; j + 1 < wn[k]; j++) begin
          wid[k][j]  = wid[k][j+1];
          wamt[k][j] = wamt[k][j+1];
        end
        wn[k]--;
        granted++;
      end else begin
        i++;
      end
    end
    return granted;
  endfunction

  // Queue a request, run the grant cascade and record the results it causes
  function automatic void settle_request(blrw_pkg::op_t op,
                                         logic [blrw_pkg::REQ_W-1:0] who,
                                         logic [AMT_W-1:0] amt);
    int k = (op == blrw_pkg::OP_GET) ? 1 : 0;
    int g;
    step_n     = 0;
    held_valid = 1'b0;
    if (wn[k] >= DEPTH) begin
      post_grant(who, blrw_pkg::OUTC_REJECT);
    end else begin
      wid[k][wn[k]]  = who;
      wamt[k][wn[k]] = amt;
      wn[k]++;
      do begin
        g = scan_waiters(0);
        g += scan_waiters(1);
      end while (g > 0 && step_n < blrw_pkg::MAX_RESULTS);
    end
    if (held_valid) begin
      held_grant.last = 1'b1;
      grant_q.insert(grant_q.size(), held_grant);
    end
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Drive requests: predict on acceptance, then offer the next one or idle
  always @(posedge clk) begin : drive_proc
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        settle_request(blrw_pkg::op_t'(in_operation), in_requester, in_amount);
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 &&
            !(phase_no != CALM_PHASE && $urandom_range(0, 99) < 37)) begin
          nxt = pend_q.pop_front();
          in_valid     <= 1'b1;
          in_operation <= nxt.op;
          in_requester <= nxt.who;
          in_amount    <= nxt.amt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random, with one long hold-off
  always @(posedge clk) begin : stall_proc
    int  hold_cnt;
    bit  hold_used;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  = 0;
      hold_used = 1'b0;
    end else if (phase_no == HOLD_PHASE && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (phase_no != CALM_PHASE) && ($urandom_range(0, 99) < 37);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : check_proc
    grant_t exp_g;
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result to=%0d outcome=%0d level=%0d last=%0b",
                                out_granted_to, out_outcome, out_level_after, out_last));
      end else begin
        exp_g = grant_q.pop_front();
        if (out_granted_to !== exp_g.who || out_outcome !== exp_g.outc ||
            out_level_after !== exp_g.lvl || out_last !== exp_g.last) begin
          flag_mismatch($sformatf(
            "got to=%0d outcome=%0d level=%0d last=%0b, want %0d/%0d/%0d/%0b",
            out_granted_to, out_outcome, out_level_after, out_last,
            exp_g.who, exp_g.outc, exp_g.lvl, exp_g.last));
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin : watchdog_proc
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STUCK_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet);
        $display("bounded_level_resource_with_waiters verification failed");
        $finish;
      end
    end
  end

  function automatic void queue_req(blrw_pkg::op_t op, logic [blrw_pkg::REQ_W-1:0] who,
                                    logic [AMT_W-1:0] amt);
    req_t r;
    r.op  = op;
    r.who = who;
    r.amt = amt;
    pend_q.insert(pend_q.size(), r);
  endfunction

  // Wait until every request is taken and every result has come, then let it drain
  task automatic settle_idle();
    while (pend_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[blrw_pkg::CAP_W-1:0];
    cap_m = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stim_proc
    int unsigned caps[RAND_PHASES];
    int unsigned scale;
    int unsigned sel;
    logic [AMT_W-1:0] amt;

    lvl_m = 0;
    cap_m = blrw_pkg::CAP_RESET;
    wn[0] = 0;
    wn[1] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero amounts, a full fill, a cascade, then both lists full
    queue_req(blrw_pkg::OP_GET, 8'h00, 16'h0000);
    queue_req(blrw_pkg::OP_PUT, 8'hFF, 16'h0000);
    queue_req(blrw_pkg::OP_PUT, 8'h01, 16'd15);
    queue_req(blrw_pkg::OP_PUT, 8'h02, 16'd1);
    queue_req(blrw_pkg::OP_GET, 8'h03, 16'hFFFF);
    queue_req(blrw_pkg::OP_GET, 8'h04, 16'd5);
    queue_req(blrw_pkg::OP_PUT, 8'h10, 16'hFFFF);
    queue_req(blrw_pkg::OP_PUT, 8'h11, 16'hAAAA);
    queue_req(blrw_pkg::OP_PUT, 8'h12, 16'h5555);
    queue_req(blrw_pkg::OP_PUT, 8'h13, 16'h8000);
    queue_req(blrw_pkg::OP_PUT, 8'h14, 16'h0010);
    queue_req(blrw_pkg::OP_PUT, 8'h15, 16'h7FFF);
    queue_req(blrw_pkg::OP_PUT, 8'h16, 16'h0100);
    queue_req(blrw_pkg::OP_PUT, 8'h17, 16'h1234);
    queue_req(blrw_pkg::OP_PUT, 8'hAA, 16'd1);
    queue_req(blrw_pkg::OP_GET, 8'h55, 16'hAAAA);
    queue_req(blrw_pkg::OP_GET, 8'h21, 16'h5555);
    queue_req(blrw_pkg::OP_GET, 8'h22, 16'h8000);
    queue_req(blrw_pkg::OP_GET, 8'h23, 16'h0020);
    queue_req(blrw_pkg::OP_GET, 8'h24, 16'h7FFF);
    queue_req(blrw_pkg::OP_GET, 8'h25, 16'h4000);
    queue_req(blrw_pkg::OP_GET, 8'h26, 16'h0FFF);
    queue_req(blrw_pkg::OP_GET, 8'hFE, 16'h0000);
    settle_idle();

    // Drop capacity below the level: puts stall, zero gets still pass
    set_capacity(5);
    queue_req(blrw_pkg::OP_PUT, 8'h30, 16'h0000);
    queue_req(blrw_pkg::OP_GET, 8'h31, 16'h0000);
    settle_idle();

    // Random phases over several capacities, extremes included
    caps = '{65535, 0, 1, $urandom_range(16, 4000), 15, $urandom_range(0, 65535), 65535};
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_idle();
      set_capacity(caps[p]);
      phase_no <= p;
      scale = (caps[p] < 4) ? 3 : caps[p] / 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) amt = '0;
        else if (sel < 18) amt = AMT_W'($urandom);
        else amt = AMT_W'($urandom_range(0, scale));
        queue_req(blrw_pkg::op_t'($urandom_range(0, 1)),
                  blrw_pkg::REQ_W'($urandom_range(0, 255)), amt);
      end
    end
    settle_idle();

    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("bounded_level_resource_with_waiters verification clean");
    end else begin
      $display("bounded_level_resource_with_waiters verification failed");
    end
    $finish;
  end

endmodule
